[hdl/cfm_pkg.sv]
// shared types, constants and helper functions of the callsign fuzzy matcher
`timescale 1ns / 1ps
package cfm_pkg;

  // string limits
  localparam int ENTRY_LEN_MAX = 12;
  localparam int TOKEN_LEN_MAX = 16;
  localparam int TOKEN_LEN_MIN = 3;
  localparam int EDIT_CAP      = 4;

  // stored word: {len[3:0], chars 8..11, chars 0..7}
  localparam int WORD_W = 100;
  typedef logic [WORD_W-1:0] entry_word_t;

  // request codes
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOMATCH = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_BADLEN  = 2'd3;

  // configuration register indexes
  localparam logic CFG_MAX_EDIT  = 1'b0;
  localparam logic CFG_MAX_CANDS = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_INS_SCAN,
    FSM_INS_CMP,
    FSM_INS_END,
    FSM_Q_RD,
    FSM_Q_LOAD,
    FSM_Q_ROW,
    FSM_Q_CELL,
    FSM_Q_EVAL,
    FSM_Q_SORT,
    FSM_OUT
  } fsm_e;

  // one slot of the best-match list
  typedef struct packed {
    logic [2:0]  edist;
    entry_word_t word;
  } best_t;

  // sort key: characters in order, first char most significant, then length
  function automatic entry_word_t sort_key(input entry_word_t w);
    entry_word_t k;
    k = '0;
    for (int b = 0; b < ENTRY_LEN_MAX; b++) begin
      k[WORD_W-1-8*b -: 8] = w[8*b +: 8];
    end
    k[3:0] = w[WORD_W-1 -: 4];
    return k;
  endfunction

  // fold a-z to upper case
  function automatic logic [7:0] fold_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

endpackage

[hdl/callsign_fuzzy_matcher_top.sv]
// callsign table with insert, clear and edit-distance top-k query
//
// channel   direction  handshake             payload
// request   in         start_i & !busy_o     req_type_i, text_low_i, text_high_i, text_len_i
// result    out        res_valid_o strobe    match_low_o, match_high_o, match_len_o,
//                                            distance_o, status_o, last_o
// config    in         cfg_we_i              cfg_idx_i, cfg_data_i
//
// clear empties the table; insert scans the stored entries for a duplicate over the
// single-port entry memory. a query runs each stored entry through the shared edit-distance
// cell unit, with list insertion for an entry that matches, then strobes the results.
// reset is asynchronous active low and empties the table; the memory needs no clearing.
// results are strobed one per cycle and the receiver cannot stall them.
`timescale 1ns / 1ps
module callsign_fuzzy_matcher_top #(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_MATCHES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] text_low_i,
  input  logic [63:0] text_high_i,
  input  logic [4:0]  text_len_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [4:0]  cfg_data_i,
  output logic        res_valid_o,
  output logic [63:0] match_low_o,
  output logic [31:0] match_high_o,
  output logic [3:0]  match_len_o,
  output logic [2:0]  distance_o,
  output logic [1:0]  status_o,
  output logic        last_o
);
  import cfm_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int MI = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
  localparam int NW = $clog2(MAX_MATCHES + 1);

  // state and control registers
  fsm_e            state_q, state_d;
  logic [2:0]      max_edit_q;
  logic [4:0]      max_cands_q;
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   addr_q;
  logic [NW-1:0]   n_q;
  logic [NW-1:0]   pos_q;
  logic [NW-1:0]   out_idx_q;
  logic [4:0]      i_q;
  logic [3:0]      j_q;
  logic            res_valid_q;

  // payload registers
  entry_word_t     mem_q [TABLE_DEPTH];
  entry_word_t     rd_data_q;
  entry_word_t     word_q;
  entry_word_t     ent_q;
  logic [3:0]      le_q;
  logic [4:0]      tok_len_q;
  logic [7:0]      tok_q [TOKEN_LEN_MAX];
  logic [4:0]      row_q [ENTRY_LEN_MAX+1];
  logic [4:0]      diag_q, left_q, dist_q;
  best_t           best_q [MAX_MATCHES];
  entry_word_t     res_word_q;
  logic [2:0]      res_dist_q;
  logic [1:0]      res_status_q;
  logic            res_last_q;

  // derived limits
  logic [2:0]      cap;
  logic [NW-1:0]   kmax;
  logic            ins_badlen;
  entry_word_t     ins_word;
  logic [127:0]    text_all;
  logic            mem_rd, mem_we;

  assign cap = (max_edit_q > 3'(EDIT_CAP)) ? 3'(EDIT_CAP) : max_edit_q;
  assign kmax = (32'(max_cands_q) > 32'(MAX_MATCHES)) ? NW'(MAX_MATCHES) : NW'(max_cands_q);
  assign ins_badlen = (text_len_i == 5'd0) || (text_len_i > 5'(ENTRY_LEN_MAX));
  assign text_all = {text_high_i, text_low_i};

  // masked insert word, bytes past the length are zero
  always_comb begin
    ins_word = '0;
    for (int b = 0; b < ENTRY_LEN_MAX; b++) begin
      if (5'(b) < text_len_i) begin
        ins_word[8*b +: 8] = text_all[8*b +: 8];
      end
    end
    ins_word[WORD_W-1 -: 4] = text_len_i[3:0];
  end

  // edit-distance cell unit
  logic [7:0] t_char, e_char;
  logic [4:0] up_val, cost_sub, cost_up, cost_left, cell_val;
  assign t_char    = tok_q[i_q[3:0]];
  assign e_char    = ent_q[8*j_q +: 8];
  assign up_val    = row_q[j_q + 4'd1];
  assign cost_sub  = diag_q + ((t_char != e_char) ? 5'd1 : 5'd0);
  assign cost_up   = up_val + 5'd1;
  assign cost_left = left_q + 5'd1;
  always_comb begin
    cell_val = cost_sub;
    if (cost_up < cell_val) cell_val = cost_up;
    if (cost_left < cell_val) cell_val = cost_left;
  end

  // shared list compare: does the slot above pos sort after the new entry
  best_t      above;
  logic       above_gt, shift_go;
  assign above    = best_q[MI'(pos_q - NW'(1))];
  assign above_gt = (above.edist > dist_q[2:0]) ||
                    ((above.edist == dist_q[2:0]) && (sort_key(above.word) > sort_key(ent_q)));
  assign shift_go = (pos_q != '0) && above_gt;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (start_i) begin
          case (req_type_i)
            REQ_INSERT: state_d = ins_badlen ? FSM_IDLE : FSM_INS_SCAN;
            REQ_QUERY: begin
              if (text_len_i <= 5'(TOKEN_LEN_MAX) && text_len_i >= 5'(TOKEN_LEN_MIN) &&
                  kmax != '0 && count_q != '0) begin
                state_d = FSM_Q_RD;
              end
            end
            default: state_d = FSM_IDLE;
          endcase
        end
      end
      FSM_INS_SCAN: state_d = (addr_q == count_q) ? FSM_INS_END : FSM_INS_CMP;
      FSM_INS_CMP:  state_d = (rd_data_q == word_q) ? FSM_IDLE : FSM_INS_SCAN;
      FSM_INS_END:  state_d = FSM_IDLE;
      FSM_Q_RD: begin
        if (addr_q == count_q) begin
          state_d = (n_q == '0) ? FSM_IDLE : FSM_OUT;
        end else begin
          state_d = FSM_Q_LOAD;
        end
      end
      FSM_Q_LOAD: state_d = FSM_Q_ROW;
      FSM_Q_ROW:  state_d = (i_q == tok_len_q) ? FSM_Q_EVAL : FSM_Q_CELL;
      FSM_Q_CELL: state_d = (j_q == le_q - 4'd1) ? FSM_Q_ROW : FSM_Q_CELL;
      FSM_Q_EVAL: state_d = (dist_q > {2'b00, cap}) ? FSM_Q_RD : FSM_Q_SORT;
      FSM_Q_SORT: state_d = shift_go ? FSM_Q_SORT : FSM_Q_RD;
      FSM_OUT:    state_d = (out_idx_q == n_q - NW'(1)) ? FSM_IDLE : FSM_OUT;
      default:    state_d = FSM_IDLE;
    endcase
  end

  // memory control outputs
  always_comb begin
    mem_rd = 1'b0;
    mem_we = 1'b0;
    case (state_q)
      FSM_INS_SCAN: mem_rd = (addr_q != count_q);
      FSM_Q_RD:     mem_rd = (addr_q != count_q);
      FSM_INS_END:  mem_we = (count_q != CW'(TABLE_DEPTH));
      default: begin
        mem_rd = 1'b0;
        mem_we = 1'b0;
      end
    endcase
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[AW-1:0]] <= word_q;
    end
    if (mem_rd) begin
      rd_data_q <= mem_q[addr_q[AW-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      max_edit_q  <= 3'd2;
      max_cands_q <= 5'd8;
      count_q     <= '0;
      addr_q      <= '0;
      n_q         <= '0;
      pos_q       <= '0;
      out_idx_q   <= '0;
      i_q         <= '0;
      j_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_EDIT:  max_edit_q  <= cfg_data_i[2:0];
          CFG_MAX_CANDS: max_cands_q <= cfg_data_i;
          default: max_edit_q <= max_edit_q;
        endcase
      end
      case (state_q)
        FSM_IDLE: begin
          addr_q <= '0;
          n_q    <= '0;
          if (start_i) begin
            case (req_type_i)
              REQ_CLEAR: begin
                count_q     <= '0;
                res_valid_q <= 1'b1;
              end
              REQ_INSERT: res_valid_q <= ins_badlen;
              REQ_QUERY:  res_valid_q <= (state_d == FSM_IDLE);
              default:    res_valid_q <= 1'b0;
            endcase
          end
        end
        FSM_INS_CMP: begin
          addr_q <= addr_q + CW'(1);
          if (rd_data_q == word_q) res_valid_q <= 1'b1;
        end
        FSM_INS_END: begin
          res_valid_q <= 1'b1;
          if (count_q != CW'(TABLE_DEPTH)) count_q <= count_q + CW'(1);
        end
        FSM_Q_RD: begin
          out_idx_q <= '0;
          if (addr_q == count_q && n_q == '0) res_valid_q <= 1'b1;
        end
        FSM_Q_LOAD: i_q <= '0;
        FSM_Q_ROW:  j_q <= '0;
        FSM_Q_CELL: begin
          if (j_q == le_q - 4'd1) begin
            i_q <= i_q + 5'd1;
          end else begin
            j_q <= j_q + 4'd1;
          end
        end
        FSM_Q_EVAL: begin
          pos_q <= n_q;
          if (dist_q > {2'b00, cap}) addr_q <= addr_q + CW'(1);
        end
        FSM_Q_SORT: begin
          if (shift_go) begin
            pos_q <= pos_q - NW'(1);
          end else begin
            addr_q <= addr_q + CW'(1);
            if (pos_q < kmax && n_q < kmax) n_q <= n_q + NW'(1);
          end
        end
        FSM_OUT: begin
          res_valid_q <= 1'b1;
          out_idx_q   <= out_idx_q + NW'(1);
        end
        default: res_valid_q <= 1'b0;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      FSM_IDLE: begin
        res_word_q   <= '0;
        res_dist_q   <= '0;
        res_last_q   <= 1'b1;
        res_status_q <= STAT_OK;
        word_q       <= ins_word;
        tok_len_q    <= text_len_i;
        for (int b = 0; b < TOKEN_LEN_MAX; b++) begin
          tok_q[b] <= fold_char(text_all[8*b +: 8]);
        end
        if (req_type_i == REQ_INSERT && ins_badlen) res_status_q <= STAT_BADLEN;
        if (req_type_i == REQ_QUERY) begin
          res_status_q <= (text_len_i > 5'(TOKEN_LEN_MAX)) ? STAT_BADLEN : STAT_NOMATCH;
        end
      end
      FSM_INS_END: begin
        if (count_q == CW'(TABLE_DEPTH)) res_status_q <= STAT_FULL;
      end
      FSM_Q_RD: res_status_q <= STAT_NOMATCH;
      FSM_Q_LOAD: begin
        ent_q <= rd_data_q;
        le_q  <= (rd_data_q[WORD_W-1 -: 4] > 4'(ENTRY_LEN_MAX)) ? 4'(ENTRY_LEN_MAX)
                                                                : rd_data_q[WORD_W-1 -: 4];
        for (int c = 0; c <= ENTRY_LEN_MAX; c++) begin
          row_q[c] <= 5'(c);
        end
      end
      FSM_Q_ROW: begin
        if (i_q == tok_len_q) begin
          dist_q <= row_q[le_q];
        end else begin
          diag_q   <= row_q[0];
          left_q   <= i_q + 5'd1;
          row_q[0] <= i_q + 5'd1;
        end
      end
      FSM_Q_CELL: begin
        row_q[j_q + 4'd1] <= cell_val;
        diag_q            <= up_val;
        left_q            <= cell_val;
      end
      FSM_Q_SORT: begin
        if (pos_q < kmax) begin
          if (shift_go) begin
            best_q[MI'(pos_q)] <= above;
          end else begin
            best_q[MI'(pos_q)] <= '{edist: dist_q[2:0], word: ent_q};
          end
        end
      end
      FSM_OUT: begin
        res_word_q   <= best_q[MI'(out_idx_q)].word;
        res_dist_q   <= best_q[MI'(out_idx_q)].edist;
        res_status_q <= STAT_OK;
        res_last_q   <= (out_idx_q == n_q - NW'(1));
      end
      default: res_last_q <= res_last_q;
    endcase
  end

  // ports
  assign busy_o       = (state_q != FSM_IDLE);
  assign res_valid_o  = res_valid_q;
  assign match_low_o  = res_word_q[63:0];
  assign match_high_o = res_word_q[95:64];
  assign match_len_o  = res_word_q[WORD_W-1 -: 4];
  assign distance_o   = res_dist_q;
  assign status_o     = res_status_q;
  assign last_o       = res_last_q;

endmodule

[test/cfm_checker.sv]
// result checker of the callsign fuzzy matcher: watches the ports, predicts and compares
`timescale 1ns / 1ps
module cfm_checker
  import cfm_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int MAX_MATCHES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] text_low_i,
  input  logic [63:0] text_high_i,
  input  logic [4:0]  text_len_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        res_valid_i,
  input  logic [63:0] match_low_i,
  input  logic [31:0] match_high_i,
  input  logic [3:0]  match_len_i,
  input  logic [2:0]  distance_i,
  input  logic [1:0]  status_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic [63:0] lo;
    logic [31:0] hi;
    logic [3:0]  len;
    logic [2:0]  edist;
    logic [1:0]  status;
    logic        last;
  } match_res_t;

  match_res_t  expected_q[$];
  logic [95:0] tbl_text[TABLE_DEPTH];
  int          tbl_len[TABLE_DEPTH];
  int          tbl_count = 0;
  logic [2:0]  edit_reg  = 3'd2;
  logic [4:0]  cands_reg = 5'd8;
  int          fails     = 0;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  task automatic report(input string what);
    fails++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  task automatic push_status(input logic [1:0] st);
    match_res_t r;
    r = '{lo: '0, hi: '0, len: '0, edist: '0, status: st, last: 1'b1};
    expected_q.insert(expected_q.size(), r);
  endtask

  // levenshtein distance, token against stored entry k
  function automatic int edit_dist(input logic [127:0] tok, input int lt, input int k);
    int prev[17];
    int cur[17];
    int le;
    int v;
    le = tbl_len[k];
    for (int j = 0; j <= le; j++) prev[j] = j;
    for (int i = 0; i < lt; i++) begin
      cur[0] = i + 1;
      for (int j = 0; j < le; j++) begin
        v = prev[j] + ((tok[8*i +: 8] != tbl_text[k][8*j +: 8]) ? 1 : 0);
        if (prev[j+1] + 1 < v) v = prev[j+1] + 1;
        if (cur[j] + 1 < v) v = cur[j] + 1;
        cur[j+1] = v;
      end
      prev = cur;
    end
    return prev[le];
  endfunction

  // byte-wise order, a proper prefix first
  function automatic bit sorts_first(input int a, input int b);
    int n;
    n = (tbl_len[a] < tbl_len[b]) ? tbl_len[a] : tbl_len[b];
    for (int i = 0; i < n; i++) begin
      if (tbl_text[a][8*i +: 8] != tbl_text[b][8*i +: 8]) begin
        return tbl_text[a][8*i +: 8] < tbl_text[b][8*i +: 8];
      end
    end
    return tbl_len[a] < tbl_len[b];
  endfunction

  task automatic predict_insert(input logic [127:0] txt, input int len);
    logic [95:0] s;
    s = '0;
    if (len == 0 || len > ENTRY_LEN_MAX) begin
      push_status(STAT_BADLEN);
      return;
    end
    for (int i = 0; i < len; i++) s[8*i +: 8] = txt[8*i +: 8];
    for (int k = 0; k < tbl_count; k++) begin
      if (tbl_text[k] == s && tbl_len[k] == len) begin
        push_status(STAT_OK);
        return;
      end
    end
    if (tbl_count >= TABLE_DEPTH) begin
      push_status(STAT_FULL);
      return;
    end
    tbl_text[tbl_count] = s;
    tbl_len[tbl_count]  = len;
    tbl_count++;
    push_status(STAT_OK);
  endtask

  task automatic predict_query(input logic [127:0] txt, input int len);
    logic [127:0] tok;
    int cap, kmax, n, best;
    int dvals[TABLE_DEPTH];
    bit used[TABLE_DEPTH];
    match_res_t r;
    if (len > TOKEN_LEN_MAX) begin
      push_status(STAT_BADLEN);
      return;
    end
    cap  = (edit_reg > EDIT_CAP) ? EDIT_CAP : edit_reg;
    kmax = (cands_reg > MAX_MATCHES) ? MAX_MATCHES : cands_reg;
    tok  = '0;
    for (int i = 0; i < len; i++) begin
      tok[8*i +: 8] = txt[8*i +: 8];
      if (tok[8*i +: 8] >= "a" && tok[8*i +: 8] <= "z") tok[8*i +: 8] -= 8'd32;
    end
    for (int k = 0; k < tbl_count; k++) begin
      dvals[k] = edit_dist(tok, len, k);
      used[k]  = (len < TOKEN_LEN_MIN) || (dvals[k] > cap);
    end
    // pick nearest first, ties in byte order
    n = 0;
    while (n < kmax) begin
      best = -1;
      for (int k = 0; k < tbl_count; k++) begin
        if (!used[k] && (best < 0 || dvals[k] < dvals[best] ||
            (dvals[k] == dvals[best] && sorts_first(k, best)))) best = k;
      end
      if (best < 0) break;
      used[best] = 1'b1;
      r.lo     = tbl_text[best][63:0];
      r.hi     = tbl_text[best][95:64];
      r.len    = 4'(tbl_len[best]);
      r.edist  = 3'(dvals[best]);
      r.status = STAT_OK;
      r.last   = 1'b0;
      expected_q.insert(expected_q.size(), r);
      n++;
    end
    if (n == 0) push_status(STAT_NOMATCH);
    else expected_q[$].last = 1'b1;
  endtask

  // request and register transfers, then result compare
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_count = 0;
      edit_reg  = 3'd2;
      cands_reg = 5'd8;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MAX_EDIT) edit_reg = cfg_data_i[2:0];
        else cands_reg = cfg_data_i;
      end
      if (start_i && !busy_i) begin
        case (req_type_i)
          REQ_CLEAR: begin
            tbl_count = 0;
            push_status(STAT_OK);
          end
          REQ_INSERT: predict_insert({text_high_i, text_low_i}, int'(text_len_i));
          REQ_QUERY:  predict_query({text_high_i, text_low_i}, int'(text_len_i));
          default: ;
        endcase
      end
      if (res_valid_i) begin
        if (expected_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          match_res_t e;
          e = expected_q.pop_front();
          if (match_low_i !== e.lo)
            report($sformatf("match_low %h, expected %h", match_low_i, e.lo));
          if (match_high_i !== e.hi)
            report($sformatf("match_high %h, expected %h", match_high_i, e.hi));
          if (match_len_i !== e.len)
            report($sformatf("match_len %0d, expected %0d", match_len_i, e.len));
          if (distance_i !== e.edist)
            report($sformatf("distance %0d, expected %0d", distance_i, e.edist));
          if (status_i !== e.status)
            report($sformatf("status %0d, expected %0d", status_i, e.status));
          if (last_i !== e.last)
            report($sformatf("last %b, expected %b", last_i, e.last));
        end
      end
    end
  end

endmodule

[test/tb.sv]
// stimulus and verdict for the callsign fuzzy matcher
`timescale 1ns / 1ps
module tb;
  import cfm_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [79:0] SYMS = "ABCDKQ0179";

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  req_type_i = REQ_CLEAR;
  logic [63:0] text_low_i = '0;
  logic [63:0] text_high_i = '0;
  logic [4:0]  text_len_i = '0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CFG_MAX_EDIT;
  logic [4:0]  cfg_data_i = '0;
  logic        res_valid_o;
  logic [63:0] match_low_o;
  logic [31:0] match_high_o;
  logic [3:0]  match_len_o;
  logic [2:0]  distance_o;
  logic [1:0]  status_o;
  logic        last_o;
  int          fail_count;
  int          pending;

  logic [127:0] pool[8];
  int           pool_len[8];
  int           idle_pct;

  callsign_fuzzy_matcher_top #(.TABLE_DEPTH(DEPTH), .MAX_MATCHES(16)) dut (.*);

  cfm_checker #(.TABLE_DEPTH(DEPTH), .MAX_MATCHES(16)) u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .req_type_i, .text_low_i, .text_high_i,
    .text_len_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .res_valid_i(res_valid_o),
    .match_low_i(match_low_o), .match_high_i(match_high_o), .match_len_i(match_len_o),
    .distance_i(distance_o), .status_i(status_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("callsign_fuzzy_matcher_top test failed");
    $finish;
  end

  function automatic logic [7:0] rand_sym();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 8'($urandom_range(255));
    if (r < 15) return 8'($urandom_range("a", "z"));
    return SYMS[8*$urandom_range(9) +: 8];
  endfunction

  // one request transfer, bytes past the length are noise
  task automatic send_req(input logic [1:0] req, input logic [127:0] txt, input int len);
    logic [127:0] v;
    v = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < 16 && i < len; i++) v[8*i +: 8] = txt[8*i +: 8];
    start_i     <= 1'b1;
    req_type_i  <= req;
    text_low_i  <= v[63:0];
    text_high_i <= v[127:64];
    text_len_i  <= 5'(len);
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // hold off until every expected result has come
  task automatic settle();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0 || busy_o);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // up to three random edits
  task automatic mutate(inout logic [127:0] t, inout int n, input int edits);
    int p;
    for (int e = 0; e < edits; e++) begin
      p = $urandom_range(n > 0 ? n - 1 : 0);
      case ($urandom_range(2))
        0: t[8*p +: 8] = rand_sym();
        1: if (n > 1) begin
          for (int i = p; i < 15; i++) t[8*i +: 8] = t[8*(i+1) +: 8];
          n--;
        end
        default: if (n < 16) begin
          for (int i = 15; i > p; i--) t[8*i +: 8] = t[8*(i-1) +: 8];
          t[8*p +: 8] = rand_sym();
          n++;
        end
      endcase
    end
  endtask

  task automatic random_batch(input int count);
    logic [127:0] t;
    int n, r, b;
    for (int it = 0; it < count; it++) begin
      b = $urandom_range(7);
      t = pool[b];
      n = pool_len[b];
      r = $urandom_range(99);
      if (r < 3) begin
        send_req(REQ_CLEAR, t, n);
      end else if (r < 38) begin
        mutate(t, n, $urandom_range(1));
        if ($urandom_range(9) == 0) n = $urandom_range(31);
        send_req(REQ_INSERT, t, n);
      end else if (r < 96) begin
        mutate(t, n, $urandom_range(3));
        if ($urandom_range(9) == 0) n = $urandom_range(31);
        send_req(REQ_QUERY, t, n);
      end else begin
        send_req(REQ_NONE, t, n);
        it--;
      end
    end
  endtask

  initial begin
    logic [127:0] t;
    for (int b = 0; b < 8; b++) begin
      pool_len[b] = (b < 6) ? $urandom_range(3, 8) : $urandom_range(9, 12);
      t = '0;
      for (int i = 0; i < pool_len[b]; i++) t[8*i +: 8] = SYMS[8*$urandom_range(9) +: 8];
      pool[b] = t;
    end
    idle_pct = 17;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: edge lengths, duplicates, case, empty table, odd request
    send_req(REQ_QUERY, "ABC", 3);
    send_req(REQ_INSERT, "X", 0);
    send_req(REQ_INSERT, "ABCDEFGHIJKLM", 13);
    send_req(REQ_INSERT, '1, 31);
    send_req(REQ_INSERT, "A", 1);
    send_req(REQ_INSERT, "LKJIHGFEDCBA", 12);
    send_req(REQ_INSERT, "KA1ABC", 6);
    send_req(REQ_INSERT, "KA1ABC", 6);
    send_req(REQ_INSERT, "cba1ak", 6);
    send_req(REQ_INSERT, {8'hff, 8'h80, 8'h00}, 3);
    send_req(REQ_QUERY, "cba1ak", 6);
    send_req(REQ_QUERY, "ka1ab", 5);
    send_req(REQ_QUERY, "KA", 2);
    send_req(REQ_QUERY, "", 0);
    send_req(REQ_QUERY, "ABCDEFGHIJKLMNOP", 16);
    send_req(REQ_QUERY, "ABCDEFGHIJKLMNOP", 17);
    send_req(REQ_QUERY, '1, 31);
    send_req(REQ_NONE, "KA1ABC", 6);
    send_req(REQ_CLEAR, "", 0);
    send_req(REQ_QUERY, "KA1ABC", 6);
    for (int b = 0; b < 8; b++) send_req(REQ_INSERT, pool[b], pool_len[b]);

    // wide window, sender idles now and then
    settle();
    write_reg(CFG_MAX_EDIT, 5'd4);
    write_reg(CFG_MAX_CANDS, 5'd16);
    random_batch(30);

    // sender idles most of the time, register values past the caps
    settle();
    idle_pct = 88;
    write_reg(CFG_MAX_EDIT, 5'd7);
    write_reg(CFG_MAX_CANDS, 5'd31);
    random_batch(30);

    // back to back, narrow window
    settle();
    idle_pct = 0;
    write_reg(CFG_MAX_EDIT, 5'd0);
    write_reg(CFG_MAX_CANDS, 5'd1);
    random_batch(20);
    settle();
    write_reg(CFG_MAX_CANDS, 5'd0);
    random_batch(6);
    settle();
    write_reg(CFG_MAX_EDIT, 5'd3);
    write_reg(CFG_MAX_CANDS, 5'd5);
    random_batch(25);

    settle();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("callsign_fuzzy_matcher_top test passed");
    end else begin
      $display("callsign_fuzzy_matcher_top test failed");
    end
    $finish;
  end

endmodule
